[design/bencode_message_decoder_unit_macros.svh]
// ----------------------------------------------------------------------------
// bencode_message_decoder_unit_macros
// Assertion macros used by the decoder back end (bmd_back).
// ----------------------------------------------------------------------------
`ifndef BENCODE_MESSAGE_DECODER_UNIT_MACROS_SVH
`define BENCODE_MESSAGE_DECODER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BMD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define BMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[design/bmd_pkg.sv]
// ----------------------------------------------------------------------------
// bmd_pkg
// Shared types and constants of the bencode message decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package bmd_pkg;
   localparam int MaxMsgBytes = 65536;
   localparam int HwaddrBytes = 6;
   localparam int IntBits     = 32;
   localparam int PosBits     = $clog2(MaxMsgBytes + 1);
   localparam int QueueDepth  = 4;
   localparam int QueueAw     = $clog2(QueueDepth);

   localparam logic [1:0] StatusDict  = 2'd0;
   localparam logic [1:0] StatusPass  = 2'd1;
   localparam logic [1:0] StatusError = 2'd2;

   // Byte classes made by the front part.
   typedef enum logic [2:0] {
      ClsOther = 3'd0, ClsDigit = 3'd1, ClsColon = 3'd2,
      ClsE = 3'd3, ClsI = 3'd4, ClsD = 3'd5
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     byte_value;
      logic           last_byte;
      byte_class_type cls;
      logic [3:0]     digit;
   } item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] msg_type;
      logic [31:0] weight_value;
      logic [31:0] priority_value;
      logic [47:0] hw_address;
      logic [15:0] id_offset;
      logic [15:0] id_length;
      logic [15:0] rid_offset;
      logic [15:0] rid_length;
      logic [15:0] key_offset;
      logic [15:0] key_length;
      logic [15:0] consumed;
   } result_type;

   typedef enum logic [7:0] {
      PhFirst    = 8'b0000_0001,
      PhPass     = 8'b0000_0010,
      PhKeyStart = 8'b0000_0100,
      PhLen      = 8'b0000_1000,
      PhKeyStr   = 8'b0001_0000,
      PhIntOpen  = 8'b0010_0000,
      PhIntDig   = 8'b0100_0000,
      PhValStr   = 8'b1000_0000
   } phase_type;

   typedef enum logic [2:0] {
      VkNone = 3'd0, VkType = 3'd1, VkWeight = 3'd2, VkPriority = 3'd3,
      VkId = 3'd4, VkRid = 3'd5, VkKey = 3'd6, VkHwaddr = 3'd7
   } kind_type;

   // Key order: type, id, rid, key, weight, priority, hwaddr.
   function automatic logic [3:0] key_len(input logic [2:0] k);
      case (k)
         3'd0: key_len = 4'd4;
         3'd1: key_len = 4'd2;
         3'd2: key_len = 4'd3;
         3'd3: key_len = 4'd3;
         3'd4: key_len = 4'd6;
         3'd5: key_len = 4'd8;
         3'd6: key_len = 4'd6;
         default: key_len = 4'd0;
      endcase
   endfunction

   function automatic kind_type key_kind(input logic [2:0] k);
      case (k)
         3'd0: key_kind = VkType;
         3'd1: key_kind = VkId;
         3'd2: key_kind = VkRid;
         3'd3: key_kind = VkKey;
         3'd4: key_kind = VkWeight;
         3'd5: key_kind = VkPriority;
         3'd6: key_kind = VkHwaddr;
         default: key_kind = VkNone;
      endcase
   endfunction

   function automatic logic [63:0] key_name(input logic [2:0] k);
      case (k)
         3'd0: key_name = {32'd0, "epyt"};
         3'd1: key_name = {48'd0, "di"};
         3'd2: key_name = {40'd0, "dir"};
         3'd3: key_name = {40'd0, "yek"};
         3'd4: key_name = {16'd0, "thgiew"};
         3'd5: key_name = "ytiroirp";
         3'd6: key_name = {16'd0, "rddawh"};
         default: key_name = 64'd0;
      endcase
   endfunction
endpackage
`default_nettype wire

[design/bmd_front.sv]
// ----------------------------------------------------------------------------
// bmd_front
// Classifies incoming bytes and writes them into the item queue.
// ----------------------------------------------------------------------------
`default_nettype none
module bmd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [7:0]        req_byte_value,
   input  wire logic              req_last_byte,
   output bmd_pkg::item_type      item,
   output logic                   item_valid,
   input  wire logic              item_take
);
   import bmd_pkg::*;

   item_type               mem_ff [QueueDepth];
   logic [QueueAw:0]       wr_ff, wr_in, rd_ff, rd_in;
   item_type               cls_item;

   // Classify the byte.
   always_comb begin
      cls_item.byte_value = req_byte_value;
      cls_item.last_byte  = req_last_byte;
      cls_item.digit      = req_byte_value[3:0];
      case (req_byte_value) inside
         ["0":"9"]: cls_item.cls = ClsDigit;
         ":":       cls_item.cls = ClsColon;
         "e":       cls_item.cls = ClsE;
         "i":       cls_item.cls = ClsI;
         "d":       cls_item.cls = ClsD;
         default:   cls_item.cls = ClsOther;
      endcase
   end

   assign full       = (wr_ff[QueueAw] != rd_ff[QueueAw]) &&
                       (wr_ff[QueueAw-1:0] == rd_ff[QueueAw-1:0]);
   assign item_valid = wr_ff != rd_ff;
   assign item       = mem_ff[rd_ff[QueueAw-1:0]];
   assign wr_in      = wr_ff + ((push && !full) ? 1'b1 : 1'b0);
   assign rd_in      = rd_ff + ((item_take && item_valid) ? 1'b1 : 1'b0);

   // Queue pointers and storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
      if (push && !full) mem_ff[wr_ff[QueueAw-1:0]] <= cls_item;
   end
endmodule
`default_nettype wire

[design/bmd_back.sv]
// ----------------------------------------------------------------------------
// bmd_back
// Parses classified bytes and queues finished message results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bencode_message_decoder_unit_macros.svh"
module bmd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  bmd_pkg::item_type      item,
   input  wire logic              item_valid,
   output logic                   item_take,
   output bmd_pkg::result_type    result,
   output logic                   empty,
   input  wire logic              pop
);
   import bmd_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [IntBits-1:0] acc_ff, acc_in;
   logic [6:0]         cand_ff, cand_in;
   logic [3:0]         kidx_ff, kidx_in;
   logic [PosBits-1:0] rem_ff, rem_in, pos_ff, pos_in, start_ff, start_in;
   kind_type           kind_ff, kind_in;
   logic [31:0]        ints_ff [3];
   logic [31:0]        ints_in [3];
   logic [63:0]        ash_ff, ash_in, hw_ff, hw_in;
   logic [15:0]        span_ff [6];
   logic [15:0]        span_in [6];
   logic               done_ff, done_in;

   result_type         rq_ff [QueueDepth];
   logic [QueueAw:0]   rw_ff, rr_ff;
   logic               rfull, emit;
   result_type         res;

   logic [PosBits-1:0] pos_inc;
   logic [1:0]         st;
   logic               fire;

   assign rfull     = (rw_ff[QueueAw] != rr_ff[QueueAw]) &&
                      (rw_ff[QueueAw-1:0] == rr_ff[QueueAw-1:0]);
   assign item_take = !rfull;
   assign fire      = item_valid && !rfull;
   assign empty     = rw_ff == rr_ff;
   assign result    = rq_ff[rr_ff[QueueAw-1:0]];
   assign pos_inc   = (pos_ff < PosBits'(MaxMsgBytes)) ? pos_ff + 1'b1 : pos_ff;

   // Parser next state for one byte.
   always_comb begin
      logic [IntBits+3:0] prod;
      logic [PosBits-1:0] len;
      logic               r_close, r_err, skip;
      phase_type          ph;
      phase_in = phase_ff; acc_in = acc_ff; cand_in = cand_ff; kidx_in = kidx_ff;
      rem_in = rem_ff; start_in = start_ff; kind_in = kind_ff; ash_in = ash_ff;
      hw_in = hw_ff; ints_in = ints_ff; span_in = span_ff; done_in = done_ff;
      pos_in = pos_inc;
      r_close = 1'b0; r_err = 1'b0; st = StatusDict; emit = 1'b0;
      prod = {4'd0, acc_ff} * 4'd10 + item.digit;
      len = acc_ff[PosBits-1:0];
      skip = 1'b0;
      if (done_ff) begin
         skip = 1'b1;
      end else if (phase_ff == PhFirst) begin
         ints_in = '{default: '0}; span_in = '{default: '0};
         hw_in = '0; ash_in = '0; acc_in = '0; cand_in = 7'h7F; kidx_in = '0;
         rem_in = '0; kind_in = VkNone; start_in = '0;
         if (item.cls == ClsD) begin
            phase_in = PhKeyStart;
            if (item.last_byte) begin emit = 1'b1; st = StatusError; end
         end else begin
            phase_in = PhPass;
            if (item.last_byte) begin emit = 1'b1; st = StatusPass; end
         end
      end else if (phase_ff == PhPass) begin
         if (item.last_byte) begin emit = 1'b1; st = StatusPass; end
      end else begin
         ph = phase_ff;
         if (ph == PhKeyStart) begin
            if (item.cls == ClsE) r_close = 1'b1;
            else begin
               kind_in = VkNone; acc_in = '0; ph = PhLen;
               len = '0; prod = (IntBits+4)'(item.digit);
            end
         end
         if (!r_close) begin
            case (ph)
               PhLen: begin
                  if (item.cls == ClsDigit) begin
                     acc_in = (prod > (IntBits+4)'(MaxMsgBytes)) ?
                              IntBits'(MaxMsgBytes) : prod[IntBits-1:0];
                     phase_in = PhLen;
                  end else if (item.cls == ClsColon) begin
                     start_in = pos_inc; rem_in = len; kidx_in = '0; ash_in = '0;
                     if (kind_in == VkNone) begin
                        for (int i = 0; i < 7; i++)
                           cand_in[i] = PosBits'(key_len(3'(i))) == len;
                        phase_in = (len == '0) ? PhKeyStart : PhKeyStr;
                     end else if (len == '0) begin
                        kind_in = VkNone; phase_in = PhKeyStart;
                        case (kind_ff)
                           VkId:  begin span_in[0] = start_in[15:0]; span_in[1] = '0; end
                           VkRid: begin span_in[2] = start_in[15:0]; span_in[3] = '0; end
                           VkKey: begin span_in[4] = start_in[15:0]; span_in[5] = '0; end
                           default: ;
                        endcase
                     end else phase_in = PhValStr;
                  end else r_err = 1'b1;
               end
               PhKeyStr: begin
                  logic [6:0]  c;
                  logic [63:0] nm;
                  kind_type    kd;
                  c = cand_ff; kd = VkNone;
                  for (int i = 0; i < 7; i++) begin
                     nm = key_name(3'(i));
                     if (kidx_ff >= key_len(3'(i)) ||
                         nm[{kidx_ff[2:0], 3'd0} +: 8] != item.byte_value)
                        c[i] = 1'b0;
                  end
                  cand_in = c;
                  if (kidx_ff != 4'd15) kidx_in = kidx_ff + 1'b1;
                  rem_in = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
                  if (rem_in == '0) begin
                     for (int i = 6; i >= 0; i--) if (c[i]) kd = key_kind(3'(i));
                     if (kd == VkNone) phase_in = PhKeyStart;
                     else begin
                        kind_in = kd; acc_in = '0;
                        phase_in = (kd == VkType || kd == VkWeight || kd == VkPriority) ?
                                   PhIntOpen : PhLen;
                     end
                  end
               end
               PhIntOpen: begin
                  if (item.cls != ClsI) r_err = 1'b1;
                  else begin acc_in = '0; phase_in = PhIntDig; end
               end
               PhIntDig: begin
                  if (item.cls == ClsDigit) acc_in = prod[IntBits-1:0];
                  else if (item.cls == ClsE) begin
                     case (kind_ff)
                        VkType:     ints_in[0] = acc_ff[31:0];
                        VkWeight:   ints_in[1] = acc_ff[31:0];
                        VkPriority: ints_in[2] = acc_ff[31:0];
                        default: ;
                     endcase
                     kind_in = VkNone; phase_in = PhKeyStart;
                  end else r_err = 1'b1;
               end
               PhValStr: begin
                  if (kind_ff == VkHwaddr && kidx_ff < 4'(HwaddrBytes) && kidx_ff < 4'd8)
                     ash_in[{kidx_ff[2:0], 3'd0} +: 8] = item.byte_value;
                  if (kidx_ff != 4'd15) kidx_in = kidx_ff + 1'b1;
                  rem_in = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
                  if (rem_in == '0) begin
                     case (kind_ff)
                        VkId:  begin span_in[0] = start_ff[15:0]; span_in[1] = acc_ff[15:0]; end
                        VkRid: begin span_in[2] = start_ff[15:0]; span_in[3] = acc_ff[15:0]; end
                        VkKey: begin span_in[4] = start_ff[15:0]; span_in[5] = acc_ff[15:0]; end
                        VkHwaddr: if (acc_ff == IntBits'(HwaddrBytes)) hw_in = ash_in;
                        default: ;
                     endcase
                     kind_in = VkNone; phase_in = PhKeyStart;
                  end
               end
               default: r_err = 1'b1;
            endcase
         end
         if (!r_close && !r_err && item.last_byte) r_err = 1'b1;
         if (r_close) begin emit = 1'b1; st = StatusDict; end
         else if (r_err) begin emit = 1'b1; st = StatusError; end
      end
      if (emit) done_in = 1'b1;
      if (item.last_byte) begin
         phase_in = PhFirst; pos_in = '0; done_in = 1'b0;
      end
      if (skip && !item.last_byte) done_in = 1'b1;
   end

   // Result assembly.
   always_comb begin
      res = '0;
      res.status = st;
      if (st == StatusDict) begin
         res.msg_type = ints_ff[0]; res.weight_value = ints_ff[1];
         res.priority_value = ints_ff[2]; res.hw_address = hw_ff[47:0];
         res.id_offset = span_ff[0]; res.id_length = span_ff[1];
         res.rid_offset = span_ff[2]; res.rid_length = span_ff[3];
         res.key_offset = span_ff[4]; res.key_length = span_ff[5];
      end
      if (st != StatusError) res.consumed = pos_inc[15:0];
   end

   // Parser registers and result queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhFirst; pos_ff <= '0; done_ff <= 1'b0;
         rw_ff <= '0; rr_ff <= '0;
      end else begin
         if (fire) begin
            phase_ff <= phase_in; pos_ff <= pos_in; done_ff <= done_in;
            if (emit) rw_ff <= rw_ff + 1'b1;
         end
         if (pop && !empty) rr_ff <= rr_ff + 1'b1;
      end
      if (fire) begin
         acc_ff <= acc_in; cand_ff <= cand_in; kidx_ff <= kidx_in; rem_ff <= rem_in;
         start_ff <= start_in; kind_ff <= kind_in; ints_ff <= ints_in;
         ash_ff <= ash_in; hw_ff <= hw_in; span_ff <= span_in;
         if (emit) rq_ff[rw_ff[QueueAw-1:0]] <= res;
      end
   end

   `BMD_ASSERT_IMPL(a_done_no_emit, clock, reset, fire && done_ff, !emit,
      "result emitted after message done")
   `BMD_ASSERT_NEXT(a_last_resets, clock, reset, fire && item.last_byte,
      phase_ff == PhFirst && pos_ff == '0, "last byte did not restart parser")
   `BMD_ASSERT_IMPL(a_pos_sat, clock, reset, 1'b1, pos_ff <= PosBits'(MaxMsgBytes),
      "byte position beyond saturation")
endmodule
`default_nettype wire

[design/bencode_message_decoder_unit.sv]
// Throughput: one byte per cycle unless the result queue is full.
// Both sides decouple through four-entry queues; the parser reads the front queue's head.
// A result is queued as the parser takes the byte that settles its status.
// Reset: synchronous, active high; clears both queues and the parser state.
`default_nettype none
module bencode_message_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_last_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_msg_type,
   output logic [31:0]      rsp_weight_value,
   output logic [31:0]      rsp_priority_value,
   output logic [47:0]      rsp_hw_address,
   output logic [15:0]      rsp_id_offset,
   output logic [15:0]      rsp_id_length,
   output logic [15:0]      rsp_rid_offset,
   output logic [15:0]      rsp_rid_length,
   output logic [15:0]      rsp_key_offset,
   output logic [15:0]      rsp_key_length,
   output logic [15:0]      rsp_consumed
);
   import bmd_pkg::*;

   item_type   item;
   logic       item_valid, item_take;
   result_type result;

   bmd_front u_front (.clock, .reset, .push, .full, .req_byte_value, .req_last_byte,
                      .item, .item_valid, .item_take);
   bmd_back  u_back (.clock, .reset, .item, .item_valid, .item_take, .result,
                     .empty, .pop);

   assign rsp_status = result.status;       assign rsp_msg_type = result.msg_type;
   assign rsp_weight_value = result.weight_value;
   assign rsp_priority_value = result.priority_value;
   assign rsp_hw_address = result.hw_address;
   assign rsp_id_offset = result.id_offset;  assign rsp_id_length = result.id_length;
   assign rsp_rid_offset = result.rid_offset; assign rsp_rid_length = result.rid_length;
   assign rsp_key_offset = result.key_offset; assign rsp_key_length = result.key_length;
   assign rsp_consumed = result.consumed;
endmodule
`default_nettype wire
